>>> rtl/bdq_pkg.sv
package bdq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned VALUE_W = 32;

  localparam logic [2:0] REQ_INS_FRONT = 3'd0;
  localparam logic [2:0] REQ_INS_BACK = 3'd1;
  localparam logic [2:0] REQ_DEL_FRONT = 3'd2;
  localparam logic [2:0] REQ_DEL_BACK = 3'd3;
  localparam logic [2:0] REQ_SEARCH = 3'd4;
  localparam logic [2:0] REQ_DEL_VALUE = 3'd5;

  typedef enum logic [2:0] {
    OP_INS_FRONT,
    OP_INS_BACK,
    OP_DEL_FRONT,
    OP_DEL_BACK,
    OP_SEARCH,
    OP_DEL_VALUE,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    op_e op;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_SHIFT = 3'b100
  } state_e;

endpackage

>>> rtl/bdq_front.sv
module bdq_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [2:0]                           req_type_i,
  input  logic signed [bdq_pkg::VALUE_W-1:0]   value_i,
  output logic                                 item_valid_o,
  output bdq_pkg::item_t                       item_o,
  input  logic                                 item_pop_i
);

  localparam int unsigned QAW = $clog2(bdq_pkg::QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(bdq_pkg::QUEUE_DEPTH + 1);

  bdq_pkg::item_t queue_q [bdq_pkg::QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           push;
  bdq_pkg::item_t item_in;

  // classify the request kind
  always_comb begin
    item_in.value = value_i;
    case (req_type_i)
      bdq_pkg::REQ_INS_FRONT: item_in.op = bdq_pkg::OP_INS_FRONT;
      bdq_pkg::REQ_INS_BACK:  item_in.op = bdq_pkg::OP_INS_BACK;
      bdq_pkg::REQ_DEL_FRONT: item_in.op = bdq_pkg::OP_DEL_FRONT;
      bdq_pkg::REQ_DEL_BACK:  item_in.op = bdq_pkg::OP_DEL_BACK;
      bdq_pkg::REQ_SEARCH:    item_in.op = bdq_pkg::OP_SEARCH;
      bdq_pkg::REQ_DEL_VALUE: item_in.op = bdq_pkg::OP_DEL_VALUE;
      default:                item_in.op = bdq_pkg::OP_NOP;
    endcase
  end

  assign busy_o = (cnt_q == QCW'(bdq_pkg::QUEUE_DEPTH));
  assign push = start_i && !busy_o;
  assign item_valid_o = (cnt_q != '0);
  assign item_o = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(bdq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
    end
    if (item_pop_i) begin
      rd_ptr_d = (rd_ptr_q == QAW'(bdq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
    end
    if (push && !item_pop_i) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (!push && item_pop_i) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCW'(bdq_pkg::QUEUE_DEPTH))
    else $error("queue count over depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !item_pop_i) |=> cnt_q == $past(cnt_q) + QCW'(1))
    else $error("push not counted");

endmodule

>>> rtl/bdq_back.sv
module bdq_back #(
  parameter int unsigned CAPACITY = bdq_pkg::CAPACITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  bdq_pkg::item_t item_i,
  output logic           item_pop_o,
  output logic           done_o,
  output logic [1:0]     status_o,
  output logic [3:0]     found_position_o,
  output logic [4:0]     entry_count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [bdq_pkg::VALUE_W-1:0] mem [CAPACITY];
  logic [bdq_pkg::VALUE_W-1:0] rd_data_q;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [AW-1:0]               mem_raddr;
  logic [bdq_pkg::VALUE_W-1:0] mem_wdata;

  bdq_pkg::state_e             state_q, state_d;
  logic [AW-1:0]               head_q, head_d;
  logic [CW-1:0]               count_q, count_d;
  logic [CW-1:0]               rd_idx_q, rd_idx_d;
  logic [CW-1:0]               cmp_idx_q, cmp_idx_d;
  logic                        cmp_vld_q, cmp_vld_d;
  logic [bdq_pkg::VALUE_W-1:0] key_q, key_d;
  logic                        del_q, del_d;
  logic                        done_q, done_d;
  bdq_pkg::status_e            status_q, status_d;
  logic [3:0]                  pos_q, pos_d;
  logic                        issue;
  logic                        is_full;
  logic                        is_empty;
  logic [AW-1:0]               head_dec;
  logic [AW-1:0]               head_inc;

  // list position to circular slot
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] idx);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(idx);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return AW'(s);
  endfunction

  assign is_full = (count_q == CW'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
  assign head_inc = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
  assign issue = (rd_idx_q < count_q);
  assign mem_raddr = phys(head_q, rd_idx_q);

  always_comb begin
    state_d = state_q;
    head_d = head_q;
    count_d = count_q;
    rd_idx_d = rd_idx_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = 1'b0;
    key_d = key_q;
    del_d = del_q;
    done_d = 1'b0;
    status_d = status_q;
    pos_d = pos_q;
    item_pop_o = 1'b0;
    mem_we = 1'b0;
    mem_waddr = head_q;
    mem_wdata = rd_data_q;
    case (state_q)
      bdq_pkg::S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          status_d = bdq_pkg::ST_OK;
          pos_d = '0;
          case (item_i.op)
            bdq_pkg::OP_INS_FRONT: begin
              done_d = 1'b1;
              if (is_full) begin
                status_d = bdq_pkg::ST_FULL;
              end else begin
                mem_we = 1'b1;
                mem_waddr = head_dec;
                mem_wdata = item_i.value;
                head_d = head_dec;
                count_d = count_q + CW'(1);
              end
            end
            bdq_pkg::OP_INS_BACK: begin
              done_d = 1'b1;
              if (is_full) begin
                status_d = bdq_pkg::ST_FULL;
              end else begin
                mem_we = 1'b1;
                mem_waddr = phys(head_q, count_q);
                mem_wdata = item_i.value;
                count_d = count_q + CW'(1);
              end
            end
            bdq_pkg::OP_DEL_FRONT: begin
              done_d = 1'b1;
              if (is_empty) begin
                status_d = bdq_pkg::ST_EMPTY;
              end else begin
                head_d = head_inc;
                count_d = count_q - CW'(1);
              end
            end
            bdq_pkg::OP_DEL_BACK: begin
              done_d = 1'b1;
              if (is_empty) begin
                status_d = bdq_pkg::ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            bdq_pkg::OP_SEARCH, bdq_pkg::OP_DEL_VALUE: begin
              if (is_empty) begin
                done_d = 1'b1;
                status_d = (item_i.op == bdq_pkg::OP_SEARCH) ? bdq_pkg::ST_NOTFOUND
                                                             : bdq_pkg::ST_EMPTY;
              end else begin
                state_d = bdq_pkg::S_SCAN;
                key_d = item_i.value;
                del_d = (item_i.op == bdq_pkg::OP_DEL_VALUE);
                rd_idx_d = '0;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      bdq_pkg::S_SCAN: begin
        // one read issued per cycle, compared in the next cycle
        if (issue) begin
          rd_idx_d = rd_idx_q + CW'(1);
        end
        cmp_vld_d = issue;
        cmp_idx_d = rd_idx_q;
        if (cmp_vld_q && (rd_data_q == key_q)) begin
          cmp_vld_d = 1'b0;
          if (del_q) begin
            state_d = bdq_pkg::S_SHIFT;
            rd_idx_d = cmp_idx_q + CW'(1);
          end else begin
            state_d = bdq_pkg::S_IDLE;
            done_d = 1'b1;
            pos_d = 4'(cmp_idx_q);
          end
        end else if (cmp_vld_q && (cmp_idx_q == count_q - CW'(1))) begin
          cmp_vld_d = 1'b0;
          state_d = bdq_pkg::S_IDLE;
          done_d = 1'b1;
          status_d = bdq_pkg::ST_NOTFOUND;
        end
      end
      bdq_pkg::S_SHIFT: begin
        // close the gap: entry i+1 moves to i
        if (issue) begin
          rd_idx_d = rd_idx_q + CW'(1);
        end
        cmp_vld_d = issue;
        cmp_idx_d = rd_idx_q;
        if (cmp_vld_q) begin
          mem_we = 1'b1;
          mem_waddr = phys(head_q, cmp_idx_q - CW'(1));
          mem_wdata = rd_data_q;
        end
        if (!issue && !cmp_vld_q) begin
          state_d = bdq_pkg::S_IDLE;
          count_d = count_q - CW'(1);
          done_d = 1'b1;
        end
      end
      default: begin
        state_d = bdq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdq_pkg::S_IDLE;
      head_q <= '0;
      count_q <= '0;
      rd_idx_q <= '0;
      cmp_vld_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      count_q <= count_d;
      rd_idx_q <= rd_idx_d;
      cmp_vld_q <= cmp_vld_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    key_q <= key_d;
    del_q <= del_d;
    status_q <= status_d;
    pos_q <= pos_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[mem_raddr];
  end

  assign done_o = done_q;
  assign status_o = status_q;
  assign found_position_o = pos_q;
  assign entry_count_o = 5'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count over capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= AW'(CAPACITY - 1))
    else $error("head slot out of range");

  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bdq_pkg::S_SCAN) |-> !mem_we)
    else $error("store written during scan");

  a_cmp_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> cmp_idx_q < count_q)
    else $error("compare beyond stored entries");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == bdq_pkg::ST_FULL) |-> count_q == CW'(CAPACITY))
    else $error("full reported below capacity");

endmodule

>>> rtl/bounded_deque_with_search_delete.sv
// ordered list of up to CAPACITY signed 32-bit values, position 0 at the front
// request channel: req_type_i and value_i are taken at a rising edge with
// start_i high and busy_o low; a two-beat queue sits ahead of the executor, so
// busy_o rises only when two requests are waiting behind the one in work
// result channel: done_o is high for exactly one cycle per request with
// status_o, found_position_o and entry_count_o; the receiver cannot stall
// and results leave in request order
// inserts, front/back deletes and unused kinds give a result in the cycle
// after the executor takes them
// search: the scan reads one stored entry per cycle from a store with separate
// read and write ports and registered read, ending at a hit or the last entry
// delete by value: scan to position p, then every entry behind p moves down
// one place and the count drops by one
// the executor takes a new beat the cycle after a short kind, and a search or
// delete by value on a non-empty list holds it until its result is given
// the list is a circular buffer, so front inserts and deletes move no data
// reset empties the list and the queue at once; no clearing pass is needed
module bounded_deque_with_search_delete #(
  parameter int unsigned CAPACITY = bdq_pkg::CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [2:0]                         req_type_i,
  input  logic signed [bdq_pkg::VALUE_W-1:0] value_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [3:0]                         found_position_o,
  output logic [4:0]                         entry_count_o
);

  logic           item_valid;
  logic           item_pop;
  bdq_pkg::item_t item;

  bdq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  bdq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (item_valid),
    .item_i           (item),
    .item_pop_o       (item_pop),
    .done_o           (done_o),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o)
  );

endmodule
